// ===== sv/dpd_pkg.sv =====
// Package: shared types, character codes and the hex digit decoder for the packet deframer.
`timescale 1ns / 1ps
package dpd_pkg;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_DIG1 = 2'd2;
  localparam logic [1:0] PH_DIG2 = 2'd3;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_GOOD   = 2'd1;
  localparam logic [1:0] KIND_BAD    = 2'd2;
  localparam logic [1:0] KIND_GIVEUP = 2'd3;

  localparam logic [6:0] CHAR_START = 7'h24;  // '$'
  localparam logic [6:0] CHAR_END   = 7'h23;  // '#'
  localparam logic [7:0] TRIES_RESET = 8'd10;
  localparam logic [7:0] COUNT_MAX   = 8'hff;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] sum;
    logic [4:0] first;   // bit 4: digit seen, bits 3..0: its value
    logic [7:0] bad;
  } dpd_state_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic [6:0] payload;
    logic [7:0] computed_sum;
  } dpd_result_t;

  // Return {1, value} for a hex digit, zero otherwise.
  function automatic logic [4:0] hex_digit(input logic [6:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[7'h30:7'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[7'h41:7'h46], [7'h61:7'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ===== sv/dpd_step.sv =====
// Next-state and result logic for one received byte.
`timescale 1ns / 1ps
module dpd_step (
  input  dpd_pkg::dpd_state_t  state,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           max_bad_tries,
  output dpd_pkg::dpd_state_t  state_nxt,
  output dpd_pkg::dpd_result_t res
);
  import dpd_pkg::*;

  logic [6:0] c;
  logic [4:0] second;
  logic [7:0] req;
  logic [7:0] bad_inc;

  assign c = rx_byte[6:0];
  assign second = hex_digit(c);
  assign bad_inc = (state.bad != COUNT_MAX) ? state.bad + 8'd1 : state.bad;

  always_comb begin
    if (!state.first[4]) begin
      req = 8'd0;
    end else if (second[4]) begin
      req = {state.first[3:0], second[3:0]};
    end else begin
      req = {4'd0, state.first[3:0]};
    end
  end

  always_comb begin
    state_nxt = state;
    res.vld = 1'b0;
    res.kind = KIND_DATA;
    res.payload = c;
    res.computed_sum = 8'd0;
    case (state.phase)
      PH_HUNT: begin
        if (c == CHAR_START) begin
          state_nxt.sum = 8'd0;
          state_nxt.phase = PH_BODY;
        end
      end
      PH_BODY: begin
        if (c == CHAR_END) begin
          state_nxt.phase = PH_DIG1;
        end else begin
          state_nxt.sum = state.sum + {1'b0, c};
          res.vld = 1'b1;
        end
      end
      PH_DIG1: begin
        state_nxt.first = hex_digit(c);
        state_nxt.phase = PH_DIG2;
      end
      PH_DIG2: begin
        if (req == state.sum) begin
          res.kind = KIND_GOOD;
          state_nxt.bad = 8'd0;
        end else if (bad_inc >= max_bad_tries) begin
          res.kind = KIND_GIVEUP;
          state_nxt.bad = 8'd0;
        end else begin
          res.kind = KIND_BAD;
          state_nxt.bad = bad_inc;
        end
        state_nxt.phase = PH_HUNT;
        state_nxt.first = 5'd0;
        res.vld = 1'b1;
        res.payload = state.sum[6:0];
        res.computed_sum = state.sum;
      end
      default: begin
        state_nxt.phase = PH_HUNT;
      end
    endcase
  end

endmodule

// ===== sv/debug_packet_deframer.sv =====
// Top level of the debug packet deframer: input register, packet state and result register.
//
//   channel | direction | ports
//   --------+-----------+----------------------------------------------
//   in      | sink      | in_valid, in_ready, in_rx_byte
//   out     | source    | out_valid, out_ready, out_kind, out_payload,
//           |           | out_computed_sum
//   cfg     | sink      | cfg_wr_en, cfg_wr_data (max_bad_tries)
//
// One byte per cycle while the output is not stalled: a transfer lands in the
// input register, then the step logic updates the packet state and, for
// payload bytes and verdicts, loads the result register as the byte advances.
// The input register advances only while the result register is empty or being
// taken, so a stall on out_ready backs up to in_ready after one held byte.
// Synchronous reset returns to hunting for '$' with max_bad_tries at 10.
`timescale 1ns / 1ps
module debug_packet_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [6:0] out_payload,
  output logic [7:0] out_computed_sum,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import dpd_pkg::*;

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic [7:0]  max_r;
  dpd_state_t  state_r;
  dpd_state_t  state_nxt;
  dpd_result_t res;
  logic        out_vld_r;
  logic [1:0]  kind_r;
  logic [6:0]  payload_r;
  logic [7:0]  sum_r;
  logic        adv;

  dpd_step u_step (
    .state         (state_r),
    .rx_byte       (in_byte_r),
    .max_bad_tries (max_r),
    .state_nxt     (state_nxt),
    .res           (res)
  );

  // advance the held byte whenever the result slot is empty or being taken
  assign adv = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      max_r <= TRIES_RESET;
      state_r <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
      if (adv) begin
        state_r <= state_nxt;
      end
      if (adv && res.vld) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
    if (adv && res.vld) begin
      kind_r <= res.kind;
      payload_r <= res.payload;
      sum_r <= res.computed_sum;
    end
  end

  assign out_valid = out_vld_r;
  assign out_kind = kind_r;
  assign out_payload = payload_r;
  assign out_computed_sum = sum_r;

  a_verdict_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
    adv && state_r.phase == PH_DIG2 |=> state_r.phase == PH_HUNT && state_r.first == 5'd0)
    else $error("phase did not return to hunting after a verdict");

  a_first_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_HUNT || state_r.phase == PH_BODY |-> state_r.first == 5'd0)
    else $error("checksum digit held outside checksum phases");

  a_bad_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bad != COUNT_MAX)
    else $error("bad count reached saturation");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready |=> out_vld_r && $stable(sum_r) && $stable(kind_r))
    else $error("held result overwritten");

  a_drop_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    adv && state_r.phase == PH_HUNT |=> !out_vld_r || $past(out_vld_r && !out_ready))
    else $error("result produced while hunting");

endmodule
